/* rtl/core/dpc_pkg.sv */
`default_nettype none

package dpc_pkg;

  localparam int TEXT_ROWS    = 25;
  localparam int WIDE_COLUMNS = 80;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_DATA_W  = 8;
  localparam int CFG_IDX_W   = 3;

  typedef enum logic [2:0] {
    MODE_TEXT40        = 3'd0,
    MODE_TEXT80        = 3'd1,
    MODE_CELL_BMP      = 3'd2,
    MODE_RGB565        = 3'd3,
    MODE_RGB332_WIDE   = 3'd4,
    MODE_RGB332_NARROW = 3'd5
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISPLAY_MODE  = 3'd0,
    REG_BG_INDEX      = 3'd1,
    REG_TEXT_INDEX    = 3'd2,
    REG_ATTR_MODE     = 3'd3,
    REG_CURSOR_COLUMN = 3'd4,
    REG_CURSOR_LINE   = 3'd5,
    REG_CURSOR_SHOWN  = 3'd6
  } reg_idx_t;

  localparam int ATTR_BG_BIT        = 0;
  localparam int ATTR_UNDERLINE_BIT = 2;

  typedef struct packed {
    mode_t       display_mode;
    logic [3:0]  background_index;
    logic [3:0]  text_index;
    logic [2:0]  attr_mode_bits;
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_line;
    logic        cursor_shown;
  } cfg_t;

  // first field in the highest bits
  typedef struct packed {
    logic [7:0] pixel_hi;
    logic [7:0] pixel_lo;
    logic [7:0] attr_byte;
    logic [7:0] char_byte;
    logic [7:0] pattern_byte;
    logic [2:0] glyph_bit;
    logic [2:0] glyph_line;
    logic [4:0] cell_line;
    logic [6:0] cell_col;
  } item_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  function automatic logic [23:0] palette(input logic [3:0] idx);
    logic [23:0] c;
    case (idx)
      4'd0:    c = 24'h000000;
      4'd1:    c = 24'hFFFFFF;
      4'd2:    c = 24'h813338;
      4'd3:    c = 24'h75CEC8;
      4'd4:    c = 24'h8E3C97;
      4'd5:    c = 24'h003B16;
      4'd6:    c = 24'h2E2C9B;
      4'd7:    c = 24'hEDF171;
      4'd8:    c = 24'h8E5029;
      4'd9:    c = 24'h553800;
      4'd10:   c = 24'hC46C71;
      4'd11:   c = 24'h4A4A4A;
      4'd12:   c = 24'h7B7B7B;
      4'd13:   c = 24'hA9FF9F;
      4'd14:   c = 24'h706DEB;
      default: c = 24'hB2B2B2;
    endcase
    return c;
  endfunction

  // v*255/7 = 36v + floor(3v/7); the small quotient is a reciprocal multiply
  function automatic logic [7:0] expand3(input logic [2:0] v);
    logic [9:0] t;
    logic [9:0] q;
    t = 10'(v) * 10'd3;
    q = 10'((16'(t) * 16'd37) >> 8);
    return 8'(10'(v) * 10'd36 + q);
  endfunction

  function automatic logic [7:0] expand2(input logic [1:0] v);
    return 8'(10'(v) * 10'd85);
  endfunction

  // v*255/31 = 8v + floor(7v/31)
  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [7:0] t;
    logic [7:0] q;
    t = 8'(v) * 8'd7;
    q = 8'((17'(t) * 17'd265) >> 13);
    return 8'({3'b0, v} << 3) + q;
  endfunction

  // v*255/63 = 4v + floor(v/21)
  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [7:0] q;
    q = 8'((12'(v) * 12'd49) >> 10);
    return 8'({2'b0, v} << 2) + q;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/dpc_cfg.sv */
`default_nettype none

module dpc_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [dpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dpc_pkg::CFG_DATA_W-1:0] cfg_data,
  output dpc_pkg::cfg_t                       cfg
);
  import dpc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (reg_idx_t'(cfg_index))
        REG_DISPLAY_MODE:  cfg_nxt.display_mode     = mode_t'(cfg_data[2:0]);
        REG_BG_INDEX:      cfg_nxt.background_index = cfg_data[3:0];
        REG_TEXT_INDEX:    cfg_nxt.text_index       = cfg_data[3:0];
        REG_ATTR_MODE:     cfg_nxt.attr_mode_bits   = cfg_data[2:0];
        REG_CURSOR_COLUMN: cfg_nxt.cursor_column    = cfg_data[6:0];
        REG_CURSOR_LINE:   cfg_nxt.cursor_line      = cfg_data[4:0];
        REG_CURSOR_SHOWN:  cfg_nxt.cursor_shown     = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.display_mode     <= MODE_TEXT40;
      cfg_r.background_index <= 4'd0;
      cfg_r.text_index       <= 4'd1;
      cfg_r.attr_mode_bits   <= 3'd0;
      cfg_r.cursor_column    <= 7'd0;
      cfg_r.cursor_line      <= 5'd0;
      cfg_r.cursor_shown     <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/dpc_shade.sv */
`default_nettype none

module dpc_shade (
  input  wire dpc_pkg::item_t  item,
  input  wire dpc_pkg::cfg_t   cfg,
  output dpc_pkg::pixel_t      pix
);
  import dpc_pkg::*;

  logic        on_screen;
  logic        inv;
  logic [7:0]  pattern;
  logic        bit_on;
  logic [3:0]  bg40_idx;
  logic [23:0] fg;
  logic [23:0] bg;
  logic [23:0] cell_c;
  logic [23:0] c;

  assign on_screen = (32'(item.cell_line) < 32'(TEXT_ROWS)) &&
                     (32'(item.cell_col) < 32'(WIDE_COLUMNS));
  assign inv = cfg.cursor_shown && on_screen &&
               (item.cell_col == cfg.cursor_column) &&
               (item.cell_line == cfg.cursor_line);

  assign bg40_idx = cfg.attr_mode_bits[ATTR_BG_BIT] ? item.attr_byte[7:4]
                                                    : cfg.background_index;

  always_comb begin
    pattern = item.pattern_byte;
    fg      = palette(item.attr_byte[3:0]);
    bg      = palette(item.attr_byte[7:4]);
    case (cfg.display_mode)
      MODE_TEXT40: begin
        bg = palette(bg40_idx);
      end
      MODE_TEXT80: begin
        fg = palette(cfg.text_index);
        bg = palette(cfg.background_index);
        // underline row forces the whole glyph row on
        if (cfg.attr_mode_bits[ATTR_UNDERLINE_BIT] && item.char_byte[7] &&
            item.glyph_line == 3'd7) begin
          pattern = 8'hFF;
        end
      end
      default: ;
    endcase
  end

  assign bit_on = pattern[item.glyph_bit] ^
                  (inv && (cfg.display_mode == MODE_TEXT40 ||
                           cfg.display_mode == MODE_TEXT80));
  assign cell_c = bit_on ? fg : bg;

  always_comb begin
    case (cfg.display_mode)
      MODE_TEXT40, MODE_TEXT80, MODE_CELL_BMP: c = cell_c;
      MODE_RGB565: c = {expand5(item.pixel_hi[7:3]),
                        expand6({item.pixel_hi[2:0], item.pixel_lo[7:5]}),
                        expand5(item.pixel_lo[4:0])};
      MODE_RGB332_WIDE, MODE_RGB332_NARROW:
        c = {expand3(item.pixel_lo[7:5]), expand3(item.pixel_lo[4:2]),
             expand2(item.pixel_lo[1:0])};
      default: c = 24'h000000;
    endcase
  end

  assign pix.red   = c[23:16];
  assign pix.green = c[15:8];
  assign pix.blue  = c[7:0];

endmodule

`default_nettype wire

/* rtl/core/display_pixel_colorizer.sv */
// Throughput: one pixel per cycle while out_tready is high; input register, one colour stage, output register.
// in_tready drops only while both registers hold pixels and out_tready is low.
// Reset (rst_n low, synchronous) empties both stages and loads register defaults.
// Configuration writes are never stalled; cfg_ready is always high.
`default_nettype none

module display_pixel_colorizer (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // cell_col, cell_line, glyph_line, glyph_bit, pattern_byte, char_byte,
  // attr_byte, pixel_lo, pixel_hi, zero pad
  input  wire logic [dpc_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // red, green, blue
  output logic [dpc_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [dpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dpc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dpc_pkg::*;

  cfg_t   cfg;
  logic   s1_valid_r;
  item_t  s1_item_r;
  pixel_t pix;
  logic   out_valid_r;
  pixel_t out_pix_r;
  logic   s1_adv;
  logic   in_acc;

  dpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dpc_shade u_shade (
    .item (s1_item_r),
    .cfg  (cfg),
    .pix  (pix)
  );

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (!out_valid_r || out_tready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= item_t'(in_tdata[$bits(item_t)-1:0]);
    end
    if (s1_adv) begin
      out_pix_r <= pix;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pix_r;

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted request did not reach the input register");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("stalled pixel lost from the input register");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced pixel did not reach the output register");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("request taken while both stages are full and stalled");

endmodule

`default_nettype wire

/* sim/tb_display_pixel_colorizer.sv */
`timescale 1ns / 100ps

module tb_display_pixel_colorizer;
  import dpc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_PHASES = 14;
  localparam int PHASE_PIXELS = 80;

  // Expected colours in request order, with a private copy of the registers.
  class colour_scoreboard;
    logic [2:0] disp_mode;
    logic [3:0] bg_idx;
    logic [3:0] fg_idx;
    logic [2:0] attr_bits;
    logic [6:0] cur_col;
    logic [4:0] cur_line;
    logic       blink_on;
    pixel_t     colour_q[$];
    int         errors;

    function new();
      disp_mode = MODE_TEXT40;
      bg_idx    = 4'd0;
      fg_idx    = 4'd1;
      attr_bits = 3'd0;
      cur_col   = 7'd0;
      cur_line  = 5'd0;
      blink_on  = 1'b1;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
      case (idx)
        REG_DISPLAY_MODE:  disp_mode = data[2:0];
        REG_BG_INDEX:      bg_idx = data[3:0];
        REG_TEXT_INDEX:    fg_idx = data[3:0];
        REG_ATTR_MODE:     attr_bits = data[2:0];
        REG_CURSOR_COLUMN: cur_col = data[6:0];
        REG_CURSOR_LINE:   cur_line = data[4:0];
        REG_CURSOR_SHOWN:  blink_on = data[0];
        default: ;
      endcase
    endfunction

    function logic [23:0] swatch(logic [3:0] i);
      case (i)
        4'd0:    return 24'h000000;
        4'd1:    return 24'hFFFFFF;
        4'd2:    return 24'h813338;
        4'd3:    return 24'h75CEC8;
        4'd4:    return 24'h8E3C97;
        4'd5:    return 24'h003B16;
        4'd6:    return 24'h2E2C9B;
        4'd7:    return 24'hEDF171;
        4'd8:    return 24'h8E5029;
        4'd9:    return 24'h553800;
        4'd10:   return 24'hC46C71;
        4'd11:   return 24'h4A4A4A;
        4'd12:   return 24'h7B7B7B;
        4'd13:   return 24'hA9FF9F;
        4'd14:   return 24'h706DEB;
        default: return 24'hB2B2B2;
      endcase
    endfunction

    function logic [7:0] widen(int v, int maxv);
      return 8'((v * 255) / maxv);
    endfunction

    function pixel_t colour_of(item_t it);
      logic [23:0] c;
      logic        on_screen;
      logic        invert;
      logic        lit;
      logic [7:0]  pat;
      logic [15:0] rgb;
      pixel_t      px;
      on_screen = (it.cell_line < TEXT_ROWS) && (it.cell_col < WIDE_COLUMNS);
      invert = blink_on && on_screen && (it.cell_col == cur_col) && (it.cell_line == cur_line);
      pat = it.pattern_byte;
      rgb = {it.pixel_hi, it.pixel_lo};
      case (disp_mode)
        MODE_TEXT40: begin
          lit = pat[it.glyph_bit] ^ invert;
          c = lit ? swatch(it.attr_byte[3:0]) :
                    swatch(attr_bits[ATTR_BG_BIT] ? it.attr_byte[7:4] : bg_idx);
        end
        MODE_TEXT80: begin
          // underline row is drawn solid
          if (attr_bits[ATTR_UNDERLINE_BIT] && it.char_byte[7] && it.glyph_line == 3'd7)
            pat = 8'hFF;
          lit = pat[it.glyph_bit] ^ invert;
          c = lit ? swatch(fg_idx) : swatch(bg_idx);
        end
        MODE_CELL_BMP: begin
          lit = pat[it.glyph_bit];
          c = lit ? swatch(it.attr_byte[3:0]) : swatch(it.attr_byte[7:4]);
        end
        MODE_RGB565:
          c = {widen(rgb[15:11], 31), widen(rgb[10:5], 63), widen(rgb[4:0], 31)};
        MODE_RGB332_WIDE, MODE_RGB332_NARROW:
          c = {widen(it.pixel_lo[7:5], 7), widen(it.pixel_lo[4:2], 7),
               widen(it.pixel_lo[1:0], 3)};
        default: c = 24'h000000;
      endcase
      px.red   = c[23:16];
      px.green = c[15:8];
      px.blue  = c[7:0];
      return px;
    endfunction

    function void note_request(item_t it);
      colour_q.push_back(colour_of(it));
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (colour_q.size() == 0) begin
        $display("%0t: pixel with none pending, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = colour_q.pop_front();
      if (want.red !== got.red) begin
        $display("%0t: red mismatch, expected %h, actual %h", $time, want.red, got.red);
        errors++;
      end
      if (want.green !== got.green) begin
        $display("%0t: green mismatch, expected %h, actual %h", $time, want.green, got.green);
        errors++;
      end
      if (want.blue !== got.blue) begin
        $display("%0t: blue mismatch, expected %h, actual %h", $time, want.blue, got.blue);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  colour_scoreboard sb = new();
  int ready_pct = 100;
  int idle_cycles = 0;

  display_pixel_colorizer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_pixel(pixel_t'(out_tdata));
    out_tready <= ($urandom_range(99) < ready_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic item_t cell_pixel(input logic [6:0] col, input logic [4:0] line,
                                       input logic [2:0] gl, input logic [2:0] gb,
                                       input logic [7:0] pat, input logic [7:0] chr,
                                       input logic [7:0] attr, input logic [7:0] lo,
                                       input logic [7:0] hi);
    item_t it;
    it.cell_col     = col;
    it.cell_line    = line;
    it.glyph_line   = gl;
    it.glyph_bit    = gb;
    it.pattern_byte = pat;
    it.char_byte    = chr;
    it.attr_byte    = attr;
    it.pixel_lo     = lo;
    it.pixel_hi     = hi;
    return it;
  endfunction

  // biased towards the cursor cell, off-screen cells and the underline row
  function automatic item_t random_pixel();
    item_t it;
    int    pick;
    pick = $urandom_range(9);
    if (pick < 3) begin
      it.cell_col  = sb.cur_col;
      it.cell_line = sb.cur_line;
    end else if (pick < 5) begin
      it.cell_col  = 7'($urandom_range(127));
      it.cell_line = 5'($urandom_range(31));
    end else begin
      it.cell_col  = 7'($urandom_range(79));
      it.cell_line = 5'($urandom_range(24));
    end
    it.glyph_line   = ($urandom_range(3) == 0) ? 3'd7 : 3'($urandom_range(7));
    it.glyph_bit    = 3'($urandom_range(7));
    it.pattern_byte = 8'($urandom);
    it.char_byte    = 8'($urandom);
    it.attr_byte    = 8'($urandom);
    it.pixel_lo     = 8'($urandom);
    it.pixel_hi     = 8'($urandom);
    return it;
  endfunction

  task automatic push_pixel(input item_t it);
    cfg_valid <= 1'b0;  // closes any register burst
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(it);
    do @(posedge clk); while (!in_tready);
    sb.note_request(it);
  endtask

  task automatic flush();
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    while (sb.colour_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic set_config(input logic [7:0] mode, input logic [7:0] bg,
                            input logic [7:0] txt, input logic [7:0] attr,
                            input logic [7:0] ccol, input logic [7:0] cline,
                            input logic [7:0] shown);
    flush();
    write_reg(REG_DISPLAY_MODE, mode);
    write_reg(REG_BG_INDEX, bg);
    write_reg(REG_TEXT_INDEX, txt);
    write_reg(REG_ATTR_MODE, attr);
    write_reg(REG_CURSOR_COLUMN, ccol);
    write_reg(REG_CURSOR_LINE, cline);
    write_reg(REG_CURSOR_SHOWN, shown);
  endtask

  task automatic send_random(input int n, input bit gapless);
    int burst;
    burst = gapless ? n : $urandom_range(1, 24);
    for (int i = 0; i < n; i++) begin
      push_pixel(random_pixel());
      burst--;
      if (burst == 0 && i != n - 1) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst = $urandom_range(1, 24);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    ready_pct = 70;

    // register defaults: text40, cursor on cell 0,0
    push_pixel(cell_pixel(0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    push_pixel(cell_pixel(127, 31, 7, 7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    push_pixel(cell_pixel(0, 0, 3, 5, 8'h20, 8'h41, 8'h2A, 8'h00, 8'h00));
    push_pixel(cell_pixel(5, 3, 2, 1, 8'h02, 8'h41, 8'h7C, 8'h00, 8'h00));

    // per-cell background, cursor on the last on-screen cell
    set_config(MODE_TEXT40, 8'd9, 8'd0, 8'd1, 8'd79, 8'd24, 8'd1);
    push_pixel(cell_pixel(79, 24, 0, 4, 8'h00, 8'h00, 8'hE3, 8'h00, 8'h00));
    push_pixel(cell_pixel(80, 24, 0, 4, 8'h00, 8'h00, 8'hE3, 8'h00, 8'h00));
    push_pixel(cell_pixel(79, 25, 0, 4, 8'h10, 8'h00, 8'hE3, 8'h00, 8'h00));

    // underline on; cursor off-screen never inverts; unmapped index is a no-op
    set_config(MODE_TEXT80, 8'd15, 8'd14, 8'd4, 8'd127, 8'd31, 8'd1);
    write_reg(REG_UNMAPPED, 8'h00);
    push_pixel(cell_pixel(127, 31, 7, 0, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00));
    push_pixel(cell_pixel(10, 10, 6, 0, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00));
    push_pixel(cell_pixel(10, 10, 7, 3, 8'h00, 8'h7F, 8'h00, 8'h00, 8'h00));

    set_config(MODE_CELL_BMP, 8'd0, 8'd1, 8'd2, 8'd10, 8'd10, 8'd1);
    push_pixel(cell_pixel(10, 10, 0, 0, 8'h01, 8'h00, 8'hF0, 8'h00, 8'h00));
    push_pixel(cell_pixel(10, 10, 0, 7, 8'h01, 8'h00, 8'h0F, 8'h00, 8'h00));

    set_config(MODE_RGB565, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd1);
    push_pixel(cell_pixel(0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    push_pixel(cell_pixel(0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF));
    push_pixel(cell_pixel(0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 8'hF8));
    push_pixel(cell_pixel(0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'hE0, 8'h07));

    set_config(MODE_RGB332_WIDE, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd1);
    push_pixel(cell_pixel(0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'hE0, 8'h00));
    push_pixel(cell_pixel(0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h1F, 8'hFF));

    set_config(MODE_RGB332_NARROW, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd1);
    push_pixel(cell_pixel(0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00));
    push_pixel(cell_pixel(0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h03, 8'h00));

    // unused mode codes give black
    set_config(8'd6, 8'd15, 8'd15, 8'd7, 8'd0, 8'd0, 8'd1);
    push_pixel(cell_pixel(0, 0, 7, 7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    set_config(8'd7, 8'd15, 8'd15, 8'd7, 8'd0, 8'd0, 8'd1);
    push_pixel(cell_pixel(0, 0, 7, 7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: set_config(MODE_TEXT40, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        1: set_config(MODE_TEXT40, 8'd15, 8'd15, 8'd7, 8'd79, 8'd24, 8'd1);
        // upper data bits set everywhere; the registers keep only their width
        2: set_config(8'hF9, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        3: set_config(MODE_TEXT80, 8'd0, 8'd15, 8'd4, 8'd79, 8'd24, 8'd1);
        default:
          set_config(8'(p % 8), 8'($urandom_range(15)), 8'($urandom_range(15)),
                     8'($urandom_range(7)), 8'($urandom_range(79)),
                     8'($urandom_range(24)), 8'($urandom_range(1)));
      endcase
      ready_pct = (p % 3 == 0) ? 100 : $urandom_range(30, 90);
      send_random(PHASE_PIXELS, p % 4 == 1);
    end

    flush();
    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

/* display_pixel_colorizer.f */
rtl/core/dpc_pkg.sv
rtl/core/dpc_cfg.sv
rtl/core/dpc_shade.sv
rtl/core/display_pixel_colorizer.sv
sim/tb_display_pixel_colorizer.sv
